// ----- hw/rtl/lag_pkg.sv -----
// lag_pkg: shared constants, request codes, payload structs and types
// for the life automaton grid. No dependencies.
package lag_pkg;

   localparam int GRID_ROWS = 32;
   localparam int GRID_COLS = 32;

   localparam int RowBitsW = 32;
   localparam int ColW     = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
   localparam int StepW    = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;

   localparam logic [1:0] REQ_SET     = 2'd0;
   localparam logic [1:0] REQ_ADVANCE = 2'd1;
   localparam logic [1:0] REQ_READ    = 2'd2;

   typedef logic [GRID_COLS-1:0] lag_row_type;

   typedef struct packed {
      logic [1:0] req_type;
      logic [4:0] row;
      logic [4:0] col;
      logic       alive;
   } lag_req_type;

   typedef struct packed {
      logic [RowBitsW-1:0] row_bits;
      logic                done_res;
   } lag_rsp_type;

   typedef struct packed {
      logic            shift_en;
      logic            set_en;
      logic [ColW-1:0] set_col;
      logic            set_val;
   } lag_cell_ctl_type;

   typedef enum logic {
      ST_IDLE,
      ST_SWEEP
   } lag_state_type;

endpackage

// ----- hw/rtl/lag_row_cell.sv -----
// lag_row_cell: one link of the row chain, holds one grid row.
// Depends on lag_pkg.
module lag_row_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  lag_pkg::lag_cell_ctl_type ctl,
   input  lag_pkg::lag_row_type      shift_in,
   output lag_pkg::lag_row_type      row_out
);
   import lag_pkg::*;

   lag_row_type row_ff;
   lag_row_type row_in;

   always_comb begin
      row_in = row_ff;
      if (ctl.shift_en) begin
         row_in = shift_in;
      end else if (ctl.set_en) begin
         row_in[ctl.set_col] = ctl.set_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
      end else begin
         row_ff <= row_in;
      end
   end

   assign row_out = row_ff;

endmodule

// ----- hw/rtl/lag_row_rule.sv -----
// lag_row_rule: next generation of one row from the rows above and below.
// Depends on lag_pkg.
module lag_row_rule (
   input  lag_pkg::lag_row_type up_row,
   input  lag_pkg::lag_row_type mid_row,
   input  lag_pkg::lag_row_type dn_row,
   output lag_pkg::lag_row_type next_row
);
   import lag_pkg::*;

   logic [GRID_COLS+1:0] up_p;
   logic [GRID_COLS+1:0] mid_p;
   logic [GRID_COLS+1:0] dn_p;
   logic [3:0]           cnt [GRID_COLS];

   // dead border on both edges, no wrap
   assign up_p  = {1'b0, up_row, 1'b0};
   assign mid_p = {1'b0, mid_row, 1'b0};
   assign dn_p  = {1'b0, dn_row, 1'b0};

   always_comb begin
      for (int c = 0; c < GRID_COLS; c++) begin
         cnt[c] = 4'(up_p[c]) + 4'(up_p[c+1]) + 4'(up_p[c+2])
                + 4'(mid_p[c]) + 4'(mid_p[c+2])
                + 4'(dn_p[c]) + 4'(dn_p[c+1]) + 4'(dn_p[c+2]);
         next_row[c] = (cnt[c] == 4'd3) || ((cnt[c] == 4'd2) && mid_row[c]);
      end
   end

endmodule

// ----- hw/rtl/life_automaton_grid.sv -----
// life_automaton_grid: bounded B3/S23 cellular automaton grid.
// Depends on lag_pkg, lag_row_cell and lag_row_rule.
//
// Requests enter on req_valid/req_ready with a lag_req_type payload; every
// request gives exactly one response on rsp_valid/rsp_ready (lag_rsp_type).
// Set cell and read row complete in the cycle of their transfer; the response
// is registered and shows up in the next cycle. Such requests can be taken
// every cycle while the receiver keeps up.
// Advance one generation rotates the row chain once around: one row a cycle
// goes through the neighbor-count logic at the chain head, with the new row
// entering the tail, and req_ready is low during the sweep.
// A single output register holds the response; a new request is taken while
// it waits only if it is being taken in the same cycle. If the receiver
// stalls, the response holds and requests are not taken.
// Reset clears every cell to dead, empties the output and returns to idle.
module life_automaton_grid (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  lag_pkg::lag_req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output lag_pkg::lag_rsp_type rsp_payload
);
   import lag_pkg::*;

   lag_state_type state_ff, state_in;
   logic [StepW-1:0] step_ff, step_in;
   lag_row_type      prev_ff, prev_in;
   logic             rsp_valid_ff, rsp_valid_in;
   lag_rsp_type      rsp_ff, rsp_in;

   lag_cell_ctl_type ctl [GRID_ROWS];
   lag_row_type      rows [GRID_ROWS];
   lag_row_type      shift_src [GRID_ROWS];
   lag_row_type      dn_row;
   lag_row_type      new_row;
   lag_row_type      read_row;
   logic [RowBitsW+GRID_COLS-1:0] read_ext;

   logic req_xfer;
   logic do_set;
   logic col_ok;
   logic last_step;
   logic sweeping;

   assign req_xfer  = req_valid && req_ready;
   assign col_ok    = 32'(req_payload.col) < 32'(GRID_COLS);
   assign do_set    = req_xfer && (req_payload.req_type == REQ_SET) && col_ok;
   assign last_step = step_ff == StepW'(GRID_ROWS - 1);
   assign sweeping  = state_ff == ST_SWEEP;

   // chain head sees row k, row k+1 in the next cell, old row k-1 in prev_ff
   assign dn_row = last_step ? '0 : rows[1];

   lag_row_rule u_rule (
      .up_row   (prev_ff),
      .mid_row  (rows[0]),
      .dn_row   (dn_row),
      .next_row (new_row)
   );

   for (genvar i = 0; i < GRID_ROWS; i++) begin : g_cell
      if (i == GRID_ROWS - 1) begin : g_tail
         assign shift_src[i] = new_row;
      end else begin : g_link
         assign shift_src[i] = rows[i+1];
      end

      assign ctl[i].shift_en = sweeping;
      assign ctl[i].set_en   = do_set && (32'(req_payload.row) == 32'(i));
      assign ctl[i].set_col  = ColW'(req_payload.col);
      assign ctl[i].set_val  = req_payload.alive;

      lag_row_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl[i]),
         .shift_in (shift_src[i]),
         .row_out  (rows[i])
      );
   end

   // row read: and-or select over the chain, rows outside the grid read as zero
   always_comb begin
      read_row = '0;
      for (int i = 0; i < GRID_ROWS; i++) begin
         if (32'(req_payload.row) == 32'(i)) begin
            read_row = read_row | rows[i];
         end
      end
   end

   assign read_ext = (RowBitsW + GRID_COLS)'(read_row);

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      prev_in      = prev_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      req_ready    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = !rsp_valid_ff || rsp_ready;
            if (req_xfer) begin
               if (req_payload.req_type == REQ_ADVANCE) begin
                  state_in = ST_SWEEP;
                  step_in  = '0;
                  prev_in  = '0;
               end else begin
                  rsp_valid_in     = 1'b1;
                  rsp_in.done_res  = 1'b1;
                  rsp_in.row_bits  = (req_payload.req_type == REQ_READ) ?
                                     read_ext[RowBitsW-1:0] : '0;
               end
            end
         end
         ST_SWEEP: begin
            prev_in = rows[0];
            step_in = step_ff + StepW'(1);
            if (last_step) begin
               state_in        = ST_IDLE;
               step_in         = '0;
               rsp_valid_in    = 1'b1;
               rsp_in.done_res = 1'b1;
               rsp_in.row_bits = '0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_ff <= prev_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // no request is taken while the chain is rotating
   a_no_req_in_sweep: assert property (@(posedge clock) disable iff (reset)
      sweeping |-> !req_ready)
      else $error("request taken during generation sweep");

   // an accepted advance starts the sweep at row zero
   a_advance_starts: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_payload.req_type == REQ_ADVANCE) |=>
      (sweeping && step_ff == '0))
      else $error("advance did not start a sweep");

   // the last sweep step returns to idle with a response pending
   a_sweep_ends: assert property (@(posedge clock) disable iff (reset)
      (sweeping && last_step) |=> (state_ff == ST_IDLE && rsp_valid_ff))
      else $error("sweep end did not produce a response");

   // the output register is empty at every sweep step after the first
   a_rsp_empty_in_sweep: assert property (@(posedge clock) disable iff (reset)
      (sweeping && step_ff != '0) |-> !rsp_valid_ff)
      else $error("response pending during sweep");

endmodule
